/* hdl/utf32_to_utf8_encoder_top_macros.svh */
// Assertion macros for the UTF-32 to UTF-8 encoder.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef UTF32_TO_UTF8_ENCODER_TOP_MACROS_SVH
`define UTF32_TO_UTF8_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define UTF8E_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define UTF8E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/utf8e_pkg.sv */
// Shared types and constants for the UTF-32 to UTF-8 encoder.
// No dependencies.
`default_nettype none

package utf8e_pkg;

  // Code point classification limits
  localparam logic [31:0] MaxCodePoint = 32'h0010_FFFF;
  localparam logic [31:0] SurrLo       = 32'h0000_D800;
  localparam logic [31:0] SurrHi       = 32'h0000_DFFF;
  localparam logic [31:0] LimitOne     = 32'h0000_0080;
  localparam logic [31:0] LimitTwo     = 32'h0000_0800;
  localparam logic [31:0] LimitThree   = 32'h0001_0000;

  // Lead byte marks and continuation prefix
  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [1:0] ContMark  = 2'b10;

  // Index of the final byte within an entry
  localparam logic [1:0] LastIdxOne   = 2'd0;
  localparam logic [1:0] LastIdxTwo   = 2'd1;
  localparam logic [1:0] LastIdxThree = 2'd2;
  localparam logic [1:0] LastIdxFour  = 2'd3;

  // One classified request: bytes lead first, index of the final byte, invalid flag
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            invalid;
  } utf8e_entry_t;

  // Write side of the queue
  typedef struct packed {
    logic         valid;
    utf8e_entry_t entry;
  } utf8e_wr_t;

  // Read side of the queue
  typedef struct packed {
    logic         valid;
    utf8e_entry_t entry;
  } utf8e_rd_t;

endpackage

`default_nettype wire

/* hdl/utf32_to_utf8_encoder_top.sv */
// Top level of the UTF-32 to UTF-8 encoder: config register, front, queue, back.
// Depends on utf8e_pkg, utf8e_front, utf8e_queue, utf8e_back and the macros header.
`default_nettype none
`include "utf32_to_utf8_encoder_top_macros.svh"

// Encodes one 32-bit code point per request into its UTF-8 bytes, lead byte
// first, one byte per cycle on the output channel while out_ready_i does not
// stall it, with last_byte_o on the final byte; the single output register of
// the back end sets that rate. A code point yields 1 to 4 bytes (1 below 0x80,
// 2 below 0x800, 3 below 0x10000, 4 up to 0x10FFFF). Code points above 0x10FFFF
// or in D800-DFFF are invalid: they yield one byte equal to the configured
// replacement byte with was_invalid_o set, or nothing at all while that byte
// is zero. The front end takes a new request every cycle while the
// QueueDepth-entry queue has room, so requests keep flowing while earlier ones
// are still being emitted. The first byte of a request passes through a queue
// slot and then the output register before it is presented. Write the
// replacement byte only while no request is in flight; the config port is
// always ready and the register resets to zero.
module utf32_to_utf8_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Code point requests
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] code_point_i,
  // Encoded bytes
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  out_byte_o,
  output      logic        last_byte_o,
  output      logic        was_invalid_o,
  // Replacement byte configuration
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [7:0]  invalid_byte_i
);
  import utf8e_pkg::*;

  logic [7:0] invalid_byte_q, invalid_byte_d;
  utf8e_wr_t  wr;
  utf8e_rd_t  rd;
  logic       q_full;
  logic       pop;
  logic       repl_ok;

  // Config register: take every write, hold otherwise
  assign cfg_ready_o    = 1'b1;
  assign invalid_byte_d = (cfg_valid_i && cfg_ready_o) ? invalid_byte_i : invalid_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_byte_q <= 8'h00;
    end else begin
      invalid_byte_q <= invalid_byte_d;
    end
  end

  // Classify and pack each request
  utf8e_front u_front (
    .code_point_i   (code_point_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .invalid_byte_i (invalid_byte_q),
    .q_full_i       (q_full),
    .wr_o           (wr)
  );

  // Decouple acceptance from byte emission
  utf8e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (q_full),
    .rd_o   (rd),
    .pop_i  (pop)
  );

  // Emit the bytes of the head request
  utf8e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_i          (rd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o),
    .was_invalid_o (was_invalid_o)
  );

  // A push into the queue only ever comes from an accepted request
  `UTF8E_ASSERT_NOW(a_push_from_accept, wr.valid, in_valid_i && in_ready_o, "push without accept")
  // A full queue is never empty
  `UTF8E_ASSERT_NOW(a_full_not_empty, !in_ready_o, rd.valid, "full queue reads as empty")
  // Pending work reaches an empty output register in the next cycle
  `UTF8E_ASSERT_NEXT(a_head_drains, rd.valid && !out_valid_o, out_valid_o, "head not emitted")
  // A replacement byte is a lone, nonzero byte equal to the configured value
  assign repl_ok = last_byte_o && (out_byte_o == invalid_byte_q) && (out_byte_o != 8'h00);
  `UTF8E_ASSERT_NOW(a_repl_byte, out_valid_o && was_invalid_o, repl_ok, "bad replacement byte")

endmodule

`default_nettype wire

/* hdl/utf8e_front.sv */
// Front end: accepts code points, classifies and packs their UTF-8 bytes.
// Depends on utf8e_pkg.
`default_nettype none

module utf8e_front (
  input  wire logic [31:0]           code_point_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [7:0]            invalid_byte_i,
  input  wire logic                  q_full_i,
  output      utf8e_pkg::utf8e_wr_t  wr_o
);
  import utf8e_pkg::*;

  logic         invalid;
  logic         drop;
  utf8e_entry_t entry;

  assign invalid = (code_point_i > MaxCodePoint) ||
                   ((code_point_i >= SurrLo) && (code_point_i <= SurrHi));
  assign drop    = invalid && (invalid_byte_i == 8'h00);

  always_comb begin
    entry       = '0;
    entry.bytes = '0;
    if (invalid) begin
      entry.bytes[0] = invalid_byte_i;
      entry.last_idx = LastIdxOne;
      entry.invalid  = 1'b1;
    end else if (code_point_i < LimitOne) begin
      entry.bytes[0] = code_point_i[7:0];
      entry.last_idx = LastIdxOne;
    end else if (code_point_i < LimitTwo) begin
      entry.bytes[0] = LeadTwo | {3'b000, code_point_i[10:6]};
      entry.bytes[1] = {ContMark, code_point_i[5:0]};
      entry.last_idx = LastIdxTwo;
    end else if (code_point_i < LimitThree) begin
      entry.bytes[0] = LeadThree | {4'b0000, code_point_i[15:12]};
      entry.bytes[1] = {ContMark, code_point_i[11:6]};
      entry.bytes[2] = {ContMark, code_point_i[5:0]};
      entry.last_idx = LastIdxThree;
    end else begin
      entry.bytes[0] = LeadFour | {5'b00000, code_point_i[20:18]};
      entry.bytes[1] = {ContMark, code_point_i[17:12]};
      entry.bytes[2] = {ContMark, code_point_i[11:6]};
      entry.bytes[3] = {ContMark, code_point_i[5:0]};
      entry.last_idx = LastIdxFour;
    end
  end

  // Stall only on a full queue; dropped requests are taken and discarded
  assign in_ready_o = !q_full_i;
  assign wr_o.valid = in_valid_i && !q_full_i && !drop;
  assign wr_o.entry = entry;

endmodule

`default_nettype wire

/* hdl/utf8e_queue.sv */
// Short queue of classified requests between front and back end.
// Depends on utf8e_pkg.
`default_nettype none

module utf8e_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire utf8e_pkg::utf8e_wr_t  wr_i,
  output      logic                  full_o,
  output      utf8e_pkg::utf8e_rd_t  rd_o,
  input  wire logic                  pop_i
);
  import utf8e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utf8e_entry_t    slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o     = (cnt_q == FullCnt);
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.entry = slots_q[rd_ptr_q];

  assign push = wr_i.valid && !full_o;
  assign pop  = pop_i && rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= wr_i.entry;
    end
  end

endmodule

`default_nettype wire

/* hdl/utf8e_back.sv */
// Back end: walks the head request byte by byte into an output register.
// Depends on utf8e_pkg.
`default_nettype none

module utf8e_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire utf8e_pkg::utf8e_rd_t  rd_i,
  output      logic                  pop_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            out_byte_o,
  output      logic                  last_byte_o,
  output      logic                  was_invalid_o
);
  import utf8e_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       inv_q;
  logic       load;
  logic       take;
  logic       is_last;

  // Refill the output register when empty or being drained
  assign load    = !out_valid_q || out_ready_i;
  assign take    = load && rd_i.valid;
  assign is_last = (idx_q == rd_i.entry.last_idx);
  assign pop_o   = take && is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = rd_i.valid;
    end
    if (take) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rd_i.entry.bytes[idx_q];
      last_q <= is_last;
      inv_q  <= rd_i.entry.invalid;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_byte_o   = last_q;
  assign was_invalid_o = inv_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the UTF-32 to UTF-8 encoder (utf32_to_utf8_encoder_top).
// Depends on the encoder RTL and its package; drives requests, predicts bytes, checks them.
`default_nettype none

module testbench;

  // Encoding limits and byte marks, kept local so the prediction stands apart
  localparam logic [31:0] CodePointMax   = 32'h0010_FFFF;
  localparam logic [31:0] SurrogateFirst = 32'h0000_D800;
  localparam logic [31:0] SurrogateLast  = 32'h0000_DFFF;
  localparam logic [31:0] OneByteLimit   = 32'h0000_0080;
  localparam logic [31:0] TwoByteLimit   = 32'h0000_0800;
  localparam logic [31:0] ThreeByteLimit = 32'h0001_0000;
  localparam logic [7:0]  LeadTwo        = 8'hC0;
  localparam logic [7:0]  LeadThree      = 8'hE0;
  localparam logic [7:0]  LeadFour       = 8'hF0;
  localparam logic [1:0]  ContPrefix     = 2'b10;

  // Run control
  localparam int ResetCycles   = 7;
  localparam int SettleCycles  = 16;   // queue of two plus the output register, with margin
  localparam int HoldCycles    = 80;   // long output back-pressure stretch
  localparam int WatchdogLimit = 2000; // cycles without any handshake

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       invalid;
  } enc_byte_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request side
  logic        in_valid   = 1'b0;
  logic [31:0] code_point = '0;
  wire         in_ready;

  // Byte side
  logic        out_ready = 1'b0;
  wire         out_valid;
  wire  [7:0]  out_byte;
  wire         last_byte;
  wire         was_invalid;

  // Replacement byte write port
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_byte  = '0;
  wire         cfg_ready;

  // Testbench state
  logic [31:0] code_points_q[$];   // requests waiting for the driver
  enc_byte_t   encoded_bytes_q[$]; // bytes the encoder owes us, oldest first
  enc_byte_t   byte_due;
  logic [7:0]  repl_byte = 8'h00;  // shadow of the replacement byte register
  int          requests_queued = 0;
  int          requests_taken = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  // Boundaries of every length class, both surrogate edges and out-of-range values
  logic [31:0] corner_points[$] = '{
    32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
    32'h0000_0800, 32'h0000_D7FF, 32'h0000_D800, 32'h0000_DBFF,
    32'h0000_DC00, 32'h0000_DFFF, 32'h0000_E000, 32'h0000_FFFF,
    32'h0001_0000, 32'h0010_FFFF, 32'h0011_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h0000_0055
  };

  utf32_to_utf8_encoder_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .code_point_i   (code_point),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .last_byte_o    (last_byte),
    .was_invalid_o  (was_invalid),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .invalid_byte_i (cfg_byte)
  );

  // Free-running clock, period of four units
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Append one predicted byte to the store of owed bytes
  function automatic void owe_byte(input logic [7:0] data, input logic last,
                                   input logic invalid);
    enc_byte_t owed;
    owed.data    = data;
    owed.last    = last;
    owed.invalid = invalid;
    encoded_bytes_q.insert(encoded_bytes_q.size(), owed);
  endfunction

  // Work out the bytes one accepted request must produce
  function automatic void encode_code_point(input logic [31:0] cp);
    if (cp > CodePointMax || (cp >= SurrogateFirst && cp <= SurrogateLast)) begin
      // A zero replacement byte swallows the request without any output
      if (repl_byte != 8'h00) begin
        owe_byte(repl_byte, 1'b1, 1'b1);
      end
      return;
    end
    if (cp < OneByteLimit) begin
      owe_byte(cp[7:0], 1'b1, 1'b0);
    end else if (cp < TwoByteLimit) begin
      owe_byte(LeadTwo | {3'b000, cp[10:6]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp < ThreeByteLimit) begin
      owe_byte(LeadThree | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[11:6]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      owe_byte(LeadFour | {5'b00000, cp[20:18]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[17:12]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[11:6]}, 1'b0, 1'b0);
      owe_byte({ContPrefix, cp[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  // Mostly well-formed code points of every length; surrogates and out-of-range
  // values make up the rest, the latter spread over all 32 bits
  function automatic logic [31:0] random_code_point();
    int unsigned pick;
    logic [31:0] cp;
    pick = $urandom_range(99);
    if (pick < 15) begin
      cp = $urandom_range(32'h0000_007F, 32'h0000_0000);
    end else if (pick < 35) begin
      cp = $urandom_range(32'h0000_07FF, 32'h0000_0080);
    end else if (pick < 60) begin
      cp = $urandom_range(32'h0000_FFFF, 32'h0000_0800);
    end else if (pick < 84) begin
      cp = $urandom_range(32'h0010_FFFF, 32'h0001_0000);
    end else if (pick < 91) begin
      cp = $urandom_range(32'h0000_DFFF, 32'h0000_D800);
    end else begin
      cp = $urandom_range(32'hFFFF_FFFF, 32'h0011_0000);
    end
    return cp;
  endfunction

  // Print one line per mismatch and count every one
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Queue one request for the driver
  task automatic send_code_point(input logic [31:0] cp);
    code_points_q.insert(code_points_q.size(), cp);
    requests_queued++;
  endtask

  // Wait until every queued request is taken and every owed byte has arrived,
  // then let the pipeline empty out in case the last requests were swallowed
  task automatic settle();
    while (requests_taken != requests_queued || encoded_bytes_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the replacement byte and mirror it in the shadow once taken
  task automatic write_invalid_byte(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_byte  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    repl_byte = value;
  endtask

  // Driver: predict on acceptance, then offer the next request or idle.
  // Hold valid and payload steady while the encoder stalls the request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_code_point(code_point);
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (code_points_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid   <= 1'b1;
          code_point <= code_points_q[0];
          code_points_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure stretch, started once on request and counted down here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Monitor: check each taken byte against the oldest owed byte, then pick
  // the next ready value; drop ready for the whole hold stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (encoded_bytes_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing owed", out_byte));
        end else begin
          byte_due = encoded_bytes_q[0];
          encoded_bytes_q.delete(0);
          if (out_byte !== byte_due.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, byte_due.data));
          end
          if (last_byte !== byte_due.last) begin
            report_mismatch($sformatf("last_byte %b, want %b on byte %02h",
                                      last_byte, byte_due.last, byte_due.data));
          end
          if (was_invalid !== byte_due.invalid) begin
            report_mismatch($sformatf("was_invalid %b, want %b on byte %02h",
                                      was_invalid, byte_due.invalid, byte_due.data));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if no channel moves anything for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequence of phases
  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: reset replacement byte (zero, so invalids vanish);
    // sender idles lightly, receiver heavily
    tx_idle_pct <= 16;
    rx_idle_pct <= 65;
    foreach (corner_points[i]) send_code_point(corner_points[i]);
    repeat (45) send_code_point(random_code_point());
    settle();

    // Phase two: largest replacement byte, idling swapped
    write_invalid_byte(8'hFF);
    tx_idle_pct <= 65;
    rx_idle_pct <= 16;
    send_code_point(32'h0000_D800);
    send_code_point(32'h0000_DFFF);
    send_code_point(32'h0011_0000);
    send_code_point(32'hFFFF_FFFF);
    repeat (45) send_code_point(random_code_point());
    settle();

    // Phase three: random replacement byte from 01 to FE, no idling, and one long
    // receiver hold so the queue fills and the request side stalls
    write_invalid_byte(8'($urandom_range(8'hFE, 8'h01)));
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    repeat (30) send_code_point(random_code_point());
    settle();

    // Phase four: write zero back explicitly, invalids dropped again
    write_invalid_byte(8'h00);
    repeat (15) send_code_point(random_code_point());
    settle();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* utf32_to_utf8_encoder_top.f */
+incdir+hdl
hdl/utf8e_pkg.sv
hdl/utf8e_front.sv
hdl/utf8e_queue.sv
hdl/utf8e_back.sv
hdl/utf32_to_utf8_encoder_top.sv
tb/sv/testbench.sv
